/* src/ptq_pkg.sv */
// Shared types, codes and constants of the preemptive priority task queue.
`default_nettype none
package ptq_pkg;

  localparam int unsigned PRIO_W   = 14;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned NEST_DEPTH_DEF  = 16;

  localparam logic [PRIO_W-1:0] IDLE_LEVEL = 14'd9999;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 2'd0,
    FN_DISPATCH = 2'd1,
    FN_FINISH   = 2'd2,
    FN_NOP      = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED       = 3'd0,
    ST_QUEUE_FULL  = 3'd1,
    ST_DISPATCHED  = 3'd2,
    ST_NO_DISPATCH = 3'd3,
    ST_FINISHED    = 3'd4,
    ST_STACK_EMPTY = 3'd5
  } status_e;

  // One queue entry: the task id above its priority.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic peek;
    logic pop;
  } q_cmd_t;

  typedef struct packed {
    logic done;
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } nest_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nest_stat_t;

endpackage
`default_nettype wire

/* src/ptq_queue.sv */
// Sorted ring-buffer task queue held in a synchronous memory.
`default_nettype none
module ptq_queue import ptq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire q_cmd_t                             cmd_i,
  input  wire entry_t                             entry_i,
  output      q_stat_t                            stat_o,
  output      entry_t                             head_o,
  output      logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_X  = (IW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {Q_IDLE, Q_RD, Q_CMP, Q_PEEK} q_state_e;

  q_state_e      state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [CW-1:0] left_q, left_d;
  entry_t        new_q, new_d;

  entry_t        mem_q [QUEUE_DEPTH];
  entry_t        rd_q;
  logic          we, re;
  logic [IW-1:0] wa, ra;
  entry_t        wd;

  logic [IW:0]   tail_sum;
  logic [IW-1:0] tail, pos_prev, head_next;
  logic          done;

  always_comb begin
    tail_sum  = {1'b0, head_q} + (IW+1)'(count_q);
    tail      = (tail_sum >= DEPTH_X) ? IW'(tail_sum - DEPTH_X) : tail_sum[IW-1:0];
    pos_prev  = (pos_q == '0) ? LAST_IDX : pos_q - IW'(1);
    head_next = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
  end

  // The insert walks from the tail toward the head, moving every entry that
  // is strictly less urgent one place back, with a read step and a compare step per entry.
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    left_d  = left_q;
    new_d   = new_q;
    we      = 1'b0;
    re      = 1'b0;
    wa      = pos_q;
    ra      = pos_prev;
    wd      = new_q;
    done    = 1'b0;
    case (state_q)
      Q_IDLE: begin
        if (cmd_i.insert) begin
          pos_d   = tail;
          left_d  = count_q;
          new_d   = entry_i;
          state_d = Q_RD;
        end else if (cmd_i.peek) begin
          re      = 1'b1;
          ra      = head_q;
          state_d = Q_PEEK;
        end else if (cmd_i.pop) begin
          head_d  = head_next;
          count_d = count_q - CW'(1);
          done    = 1'b1;
        end
      end
      Q_RD: begin
        if (left_q == '0) begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
          done    = 1'b1;
          state_d = Q_IDLE;
        end else begin
          re      = 1'b1;
          state_d = Q_CMP;
        end
      end
      Q_CMP: begin
        we = 1'b1;
        if (rd_q.prio > new_q.prio) begin
          wd      = rd_q;
          pos_d   = pos_prev;
          left_d  = left_q - CW'(1);
          state_d = Q_RD;
        end else begin
          count_d = count_q + CW'(1);
          done    = 1'b1;
          state_d = Q_IDLE;
        end
      end
      Q_PEEK: begin
        done    = 1'b1;
        state_d = Q_IDLE;
      end
      default: state_d = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      left_q  <= '0;
      new_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      left_q  <= left_d;
      new_q   <= new_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem_q[ra];
    end
  end

  assign stat_o.done  = done;
  assign stat_o.full  = (count_q == DEPTH_C);
  assign stat_o.empty = (count_q == '0);
  assign head_o       = rd_q;
  assign count_o      = count_q;

endmodule
`default_nettype wire

/* src/ptq_nest.sv */
// Nesting stack of saved running levels held in a synchronous memory.
`default_nettype none
module ptq_nest import ptq_pkg::*; #(
  parameter int unsigned NEST_DEPTH = NEST_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire nest_cmd_t         cmd_i,
  input  wire logic [PRIO_W-1:0] level_i,
  output      nest_stat_t        stat_o,
  output      logic [PRIO_W-1:0] level_o
);

  localparam int unsigned NW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int unsigned DW = $clog2(NEST_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_C = DW'(NEST_DEPTH);

  logic [DW-1:0]     depth_q, depth_d;
  logic [DW-1:0]     depth_dec;
  logic [PRIO_W-1:0] mem_q [NEST_DEPTH];
  logic [PRIO_W-1:0] rd_q;

  assign depth_dec = depth_q - DW'(1);

  always_comb begin
    depth_d = depth_q;
    if (cmd_i.push) begin
      depth_d = depth_q + DW'(1);
    end else if (cmd_i.pop) begin
      depth_d = depth_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // The popped level is registered and appears on level_o in the cycle after the pop.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[depth_q[NW-1:0]] <= level_i;
    end
    if (cmd_i.pop) begin
      rd_q <= mem_q[depth_dec[NW-1:0]];
    end
  end

  assign stat_o.full  = (depth_q == DEPTH_C);
  assign stat_o.empty = (depth_q == '0);
  assign level_o      = rd_q;

endmodule
`default_nettype wire

/* src/preemptive_priority_task_queue_core.sv */
// Top level of the preemptive priority task queue: control sequencer and output register.
// Steps per input transaction: a dispatch peeks at the queue head and, if it preempts, pops
// it; an add walks the queue from the tail, moving each queued task less urgent than it (fewer
// than QUEUE_DEPTH) one place back; a finish pops the nesting stack; refusals at acceptance go
// straight to output. One item is worked at a time; the read-modify-write walk of the queue memory
// sets the rate. Asynchronous active-low reset empties the queue and the nesting stack and
// sets the running level to the idle level 9999; the memories themselves are not cleared.
`default_nettype none
module preemptive_priority_task_queue_core import ptq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned NEST_DEPTH  = NEST_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output      logic                  s_axis_tready_o,
  // tdata from bit 0: func[1:0], task_id[9:2], priority_req[23:10].
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output      logic                  m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // tdata from bit 0: status[2:0], out_task_id[10:3], out_priority[24:11],
  // running_priority[38:25], pending_count[43:39], zero fill[47:44].
  output      logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INSERT, S_PEEK, S_POP, S_FINISH, S_OUT
  } state_e;

  // Input transaction fields.
  logic [FUNC_W-1:0] in_func;
  logic [ID_W-1:0]   in_id;
  logic [PRIO_W-1:0] in_prio;
  logic              accept;

  assign in_func = s_axis_tdata_i[1:0];
  assign in_id   = s_axis_tdata_i[9:2];
  assign in_prio = s_axis_tdata_i[23:10];

  state_e            state_q, state_d;
  logic [PRIO_W-1:0] cur_q, cur_d;
  status_e           res_status_q, res_status_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic [PRIO_W-1:0] res_prio_q, res_prio_d;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [ID_W-1:0]       out_id_q, out_id_d;
  logic [PRIO_W-1:0]     out_prio_q, out_prio_d;
  logic [PRIO_W-1:0]     out_run_q, out_run_d;
  logic [COUNT_W-1:0]    out_count_q, out_count_d;

  q_cmd_t            q_cmd;
  q_stat_t           q_stat;
  entry_t            q_entry;
  entry_t            q_head;
  logic [CW-1:0]     q_count;
  nest_cmd_t         n_cmd;
  nest_stat_t        n_stat;
  logic [PRIO_W-1:0] n_level;

  assign q_entry.id   = in_id;
  assign q_entry.prio = in_prio;

  ptq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_cmd),
    .entry_i(q_entry),
    .stat_o (q_stat),
    .head_o (q_head),
    .count_o(q_count)
  );

  ptq_nest #(
    .NEST_DEPTH(NEST_DEPTH)
  ) u_nest (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (n_cmd),
    .level_i(cur_q),
    .stat_o (n_stat),
    .level_o(n_level)
  );

  // A new transaction is taken whenever the sequencer is idle; a finished
  // result may still be waiting in the output register at that time.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_prio_d   = res_prio_q;
    q_cmd        = '0;
    n_cmd        = '0;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_prio_d   = out_prio_q;
    out_run_d    = out_run_q;
    out_count_d  = out_count_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_id_d     = '0;
          res_prio_d   = '0;
          res_status_d = ST_NO_DISPATCH;
          state_d      = S_OUT;
          case (func_e'(in_func))
            FN_ADD: begin
              if (q_stat.full) begin
                res_status_d = ST_QUEUE_FULL;
              end else begin
                q_cmd.insert = 1'b1;
                state_d      = S_INSERT;
              end
            end
            FN_DISPATCH: begin
              // Both an empty queue and a full nesting stack refuse outright.
              if (!q_stat.empty && !n_stat.full) begin
                q_cmd.peek = 1'b1;
                state_d    = S_PEEK;
              end
            end
            FN_FINISH: begin
              if (n_stat.empty) begin
                res_status_d = ST_STACK_EMPTY;
              end else begin
                n_cmd.pop = 1'b1;
                state_d   = S_FINISH;
              end
            end
            default: begin
              res_status_d = ST_NO_DISPATCH;
            end
          endcase
        end
      end
      S_INSERT: begin
        if (q_stat.done) begin
          res_status_d = ST_ADDED;
          state_d      = S_OUT;
        end
      end
      S_PEEK: begin
        // The head entry is valid here; it preempts only if strictly more urgent.
        if (q_stat.done) begin
          if (q_head.prio < cur_q) begin
            res_id_d     = q_head.id;
            res_prio_d   = q_head.prio;
            res_status_d = ST_DISPATCHED;
            state_d      = S_POP;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_POP: begin
        // Drop the head, save the running level and raise the new one.
        q_cmd.pop  = 1'b1;
        n_cmd.push = 1'b1;
        cur_d      = res_prio_q;
        state_d    = S_OUT;
      end
      S_FINISH: begin
        cur_d        = n_level;
        res_status_d = ST_FINISHED;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = res_id_q;
          out_prio_d   = res_prio_q;
          out_run_d    = cur_q;
          out_count_d  = COUNT_W'(q_count);
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= IDLE_LEVEL;
      res_status_q <= ST_NO_DISPATCH;
      res_id_q     <= '0;
      res_prio_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_id_q     <= '0;
      out_prio_q   <= '0;
      out_run_q    <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_prio_q   <= res_prio_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_prio_q   <= out_prio_d;
      out_run_q    <= out_run_d;
      out_count_q  <= out_count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, out_count_q, out_run_q, out_prio_q, out_id_q,
                            out_status_q};

  // A dispatched task's priority becomes the running level it reports.
  a_dispatch_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ST_DISPATCHED) |-> (out_run_q == out_prio_q))
    else $error("dispatched priority differs from running level");

  // Only a dispatch carries a task id and priority.
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != ST_DISPATCHED) |-> (out_id_q == '0) && (out_prio_q == '0))
    else $error("non-dispatch result carries task fields");

  // Never insert into a full queue nor push onto a full stack.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cmd.insert |-> !q_stat.full) and (n_cmd.push |-> !n_stat.full))
    else $error("write into a full store");

  // A finish that pops a level always goes through the finish state, which reports finished.
  a_finish_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_cmd.pop |=> (state_q == S_FINISH))
    else $error("stack pop without finish step");

endmodule
`default_nettype wire
